[rtl/core/sstps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstps_pkg
// Shared types, codes and constants of the servo slot table pulse setter.
// ----------------------------------------------------------------------------
package sstps_pkg;

    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int US_W      = 16;
    localparam int PIN_W     = 8;
    localparam int COUNT_W   = 8;
    localparam int CMD_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int OUT_SLOT_W = 3;
    localparam int CFG_IDX_W = 3;

    // Clamped angle, its product with a width span, and the division by 180.
    localparam int ANGLE_W   = 8;
    localparam int ANGLE_MAX = 180;
    localparam int PROD_W    = ANGLE_W + US_W;
    localparam int ALU_W     = US_W;

    // The division by 180 is a multiplication by 2^32 / 180, rounded up, and
    // a shift by 32. It is exact for every dividend below 2^24.
    localparam int                 RECIP_W     = 25;
    localparam int                 RECIP_SHIFT = 32;
    localparam logic [RECIP_W-1:0] RECIP_180   = 25'd23860930;
    localparam int                 QUOT_W      = PROD_W + RECIP_W;

    localparam logic [CMD_W-1:0] CMD_ATTACH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DETACH   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WR_ANGLE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WR_US    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ATT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_PULSE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REFRESH       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSES        = 3'd4;

    localparam logic [US_W-1:0]    RST_MIN_PULSE     = 16'd1000;
    localparam logic [US_W-1:0]    RST_MAX_PULSE     = 16'd2000;
    localparam logic [US_W-1:0]    RST_DEFAULT_PULSE = 16'd1500;
    localparam logic [US_W-1:0]    RST_REFRESH       = 16'd20000;
    localparam logic [COUNT_W-1:0] RST_PULSES        = 8'd10;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef enum logic
    {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed
    {
        alu_op_t          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    // For a subtraction, carry set means a borrow (a < b).
    typedef struct packed
    {
        logic [ALU_W-1:0] res;
        logic             carry;
    } alu_rsp_t;

    typedef struct packed
    {
        logic             attach;
        logic             detach;
        logic             set_width;
        slot_t            idx;
        logic [PIN_W-1:0] pin;
        logic [US_W-1:0]  width;
    } tbl_wr_t;

endpackage

[rtl/core/servo_slot_table_pulse_setter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_slot_table_pulse_setter
// Servo slot table with attach, detach, width setting and query commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays high
// until the result has been computed, and the result appears for exactly one
// cycle with done high, so it must be captured in that cycle. Every command
// first scans the slots one per cycle. Detach and failed commands then end;
// attach and query go on to the low time, write microseconds first clamps the
// request to the limits, and write angle first scales the width span by the
// angle and divides by 180, a single multiplication by a scaled reciprocal.
// busy drops in the cycle that shows done, so the next command can be issued
// right then. Configuration writes are always ready and should be made only
// while no command is in flight.
// ----------------------------------------------------------------------------
module servo_slot_table_pulse_setter
    import sstps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [CMD_W-1:0]      cmd,
    input  logic [PIN_W-1:0]      pin_id,
    input  logic signed [US_W-1:0] angle_deg,
    input  logic [US_W-1:0]       width_request_us,
    output logic                  done,
    output logic [STATUS_W-1:0]   status,
    output logic [OUT_SLOT_W-1:0] slot_index,
    output logic                  is_attached,
    output logic [US_W-1:0]       pulse_us,
    output logic [US_W-1:0]       low_time_us,
    output logic [COUNT_W-1:0]    pulse_count,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [US_W-1:0]       cfg_data
);

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_DIFF_A,
        S_DIFF_B,
        S_MUL,
        S_DIV,
        S_MAP,
        S_CLAMP_LO,
        S_CLAMP_HI,
        S_LOWT
    } state_t;

    // Configuration registers.
    logic [US_W-1:0]    min_reg, max_reg, dflt_reg, refresh_reg;
    logic [COUNT_W-1:0] ppu_reg;

    // Sequencer state and working registers.
    state_t               state_reg, state_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [PIN_W-1:0]     pin_reg, pin_next;
    logic [ANGLE_W-1:0]   ang_reg, ang_next;
    logic [US_W-1:0]      wreq_reg, wreq_next;
    slot_t                idx_reg, idx_next;
    logic                 free_found_reg, free_found_next;
    slot_t                free_idx_reg, free_idx_next;
    logic                 match_found_reg, match_found_next;
    slot_t                match_idx_reg, match_idx_next;
    logic                 dup_reg, dup_next;
    logic [US_W-1:0]      diff_reg, diff_next;
    logic                 minus_reg, minus_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [US_W-1:0]      pw_reg, pw_next;

    // Result registers.
    logic                 done_reg, done_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    slot_t                slot_reg, slot_next;
    logic                 att_reg, att_next;
    logic [US_W-1:0]      pulse_reg, pulse_next;
    logic [US_W-1:0]      low_reg, low_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    alu_req_t             alu_req;
    alu_rsp_t             alu_rsp;
    tbl_wr_t              tbl_wr;
    logic                 scan_used;
    logic [PIN_W-1:0]     scan_pin;
    logic [US_W-1:0]      rd_width;
    logic [QUOT_W-1:0]    quot_full;
    logic                 accept;

    sstps_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    sstps_slot_table u_table
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .scan_idx  (idx_reg),
        .rd_idx    (match_idx_reg),
        .wr        (tbl_wr),
        .scan_used (scan_used),
        .scan_pin  (scan_pin),
        .rd_width  (rd_width)
    );

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign quot_full = QUOT_W'(prod_reg) * QUOT_W'(RECIP_180);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg     <= RST_MIN_PULSE;
            max_reg     <= RST_MAX_PULSE;
            dflt_reg    <= RST_DEFAULT_PULSE;
            refresh_reg <= RST_REFRESH;
            ppu_reg     <= RST_PULSES;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MIN_PULSE:     min_reg     <= cfg_data;
                REG_MAX_PULSE:     max_reg     <= cfg_data;
                REG_DEFAULT_PULSE: dflt_reg    <= cfg_data;
                REG_REFRESH:       refresh_reg <= cfg_data;
                REG_PULSES:        ppu_reg     <= cfg_data[COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Shared adder operand selection.
    always_comb
    begin
        alu_req.op = ALU_SUB;
        alu_req.a  = '0;
        alu_req.b  = '0;
        case (state_reg)
            S_DIFF_A:
            begin
                alu_req.a = max_reg;
                alu_req.b = min_reg;
            end
            S_DIFF_B:
            begin
                alu_req.a = min_reg;
                alu_req.b = max_reg;
            end
            S_MAP:
            begin
                alu_req.op = minus_reg ? ALU_SUB : ALU_ADD;
                alu_req.a  = min_reg;
                alu_req.b  = prod_reg[US_W-1:0];
            end
            S_CLAMP_LO:
            begin
                alu_req.a = wreq_reg;
                alu_req.b = min_reg;
            end
            S_CLAMP_HI:
            begin
                alu_req.a = max_reg;
                alu_req.b = pw_reg;
            end
            S_LOWT:
            begin
                alu_req.a = refresh_reg;
                alu_req.b = pw_reg;
            end
            default:
            begin
                alu_req.op = ALU_SUB;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        pin_next         = pin_reg;
        ang_next         = ang_reg;
        wreq_next        = wreq_reg;
        idx_next         = idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        dup_next         = dup_reg;
        diff_next        = diff_reg;
        minus_next       = minus_reg;
        prod_next        = prod_reg;
        pw_next          = pw_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        slot_next        = slot_reg;
        att_next         = att_reg;
        pulse_next       = pulse_reg;
        low_next         = low_reg;
        count_next       = count_reg;

        tbl_wr           = '0;
        tbl_wr.pin       = pin_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next         = cmd;
                    pin_next         = pin_id;
                    wreq_next        = width_request_us;
                    if (angle_deg[US_W-1])
                        ang_next = '0;
                    else if (angle_deg > US_W'(ANGLE_MAX))
                        ang_next = ANGLE_W'(ANGLE_MAX);
                    else
                        ang_next = angle_deg[ANGLE_W-1:0];
                    idx_next         = '0;
                    free_found_next  = 1'b0;
                    free_idx_next    = '0;
                    match_found_next = 1'b0;
                    match_idx_next   = '0;
                    dup_next         = 1'b0;
                    state_next       = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (!scan_used && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                if (scan_used && (scan_pin == pin_reg))
                begin
                    if (!match_found_reg)
                    begin
                        match_found_next = 1'b1;
                        match_idx_next   = idx_reg;
                    end
                    else
                    begin
                        dup_next = 1'b1;
                    end
                end
                if (idx_reg == SLOT_W'(SLOTS - 1))
                    state_next = S_DECIDE;
                else
                    idx_next = idx_reg + 1'b1;
            end

            S_DECIDE:
            begin
                status_next = ST_OK;
                slot_next   = '0;
                att_next    = 1'b0;
                pulse_next  = '0;
                low_next    = '0;
                count_next  = '0;
                if (cmd_reg == CMD_ATTACH)
                begin
                    if (free_found_reg)
                    begin
                        tbl_wr.attach = 1'b1;
                        tbl_wr.idx    = free_idx_reg;
                        tbl_wr.width  = dflt_reg;
                        slot_next     = free_idx_reg;
                        att_next      = 1'b1;
                        pw_next       = dflt_reg;
                        count_next    = ppu_reg;
                        state_next    = S_LOWT;
                    end
                    else
                    begin
                        status_next = ST_NO_FREE;
                        att_next    = match_found_reg;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else if (!match_found_reg)
                begin
                    status_next = ST_NOT_ATT;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    slot_next = match_idx_reg;
                    att_next  = 1'b1;
                    case (cmd_reg)
                        CMD_DETACH:
                        begin
                            tbl_wr.detach = 1'b1;
                            tbl_wr.idx    = match_idx_reg;
                            att_next      = dup_reg;
                            done_next     = 1'b1;
                            state_next    = S_IDLE;
                        end
                        CMD_WR_ANGLE:
                        begin
                            count_next = ppu_reg;
                            state_next = S_DIFF_A;
                        end
                        CMD_WR_US:
                        begin
                            count_next = ppu_reg;
                            state_next = S_CLAMP_LO;
                        end
                        default:
                        begin
                            // Query, and the unused codes that act as one.
                            pw_next    = rd_width;
                            state_next = S_LOWT;
                        end
                    endcase
                end
            end

            S_DIFF_A:
            begin
                diff_next  = alu_rsp.res;
                minus_next = 1'b0;
                state_next = alu_rsp.carry ? S_DIFF_B : S_MUL;
            end

            S_DIFF_B:
            begin
                diff_next  = alu_rsp.res;
                minus_next = 1'b1;
                state_next = S_MUL;
            end

            S_MUL:
            begin
                prod_next  = PROD_W'(ang_reg) * PROD_W'(diff_reg);
                state_next = S_DIV;
            end

            S_DIV:
            begin
                // The quotient by 180 never exceeds the width span.
                prod_next  = PROD_W'(quot_full[QUOT_W-1:RECIP_SHIFT]);
                state_next = S_MAP;
            end

            S_MAP:
            begin
                pw_next    = alu_rsp.res;
                state_next = S_LOWT;
            end

            S_CLAMP_LO:
            begin
                pw_next    = alu_rsp.carry ? min_reg : wreq_reg;
                state_next = S_CLAMP_HI;
            end

            S_CLAMP_HI:
            begin
                if (alu_rsp.carry)
                    pw_next = max_reg;
                state_next = S_LOWT;
            end

            S_LOWT:
            begin
                if ((cmd_reg == CMD_WR_ANGLE) || (cmd_reg == CMD_WR_US))
                begin
                    tbl_wr.set_width = 1'b1;
                    tbl_wr.idx       = match_idx_reg;
                    tbl_wr.width     = pw_reg;
                end
                pulse_next = pw_reg;
                low_next   = alu_rsp.carry ? '0 : alu_rsp.res;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            slot_reg   <= '0;
            att_reg    <= 1'b0;
            pulse_reg  <= '0;
            low_reg    <= '0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            slot_reg   <= slot_next;
            att_reg    <= att_next;
            pulse_reg  <= pulse_next;
            low_reg    <= low_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        pin_reg         <= pin_next;
        ang_reg         <= ang_next;
        wreq_reg        <= wreq_next;
        idx_reg         <= idx_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        match_found_reg <= match_found_next;
        match_idx_reg   <= match_idx_next;
        dup_reg         <= dup_next;
        diff_reg        <= diff_next;
        minus_reg       <= minus_next;
        prod_reg        <= prod_next;
        pw_reg          <= pw_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign slot_index  = OUT_SLOT_W'(slot_reg);
    assign is_attached = att_reg;
    assign pulse_us    = pulse_reg;
    assign low_time_us = low_reg;
    assign pulse_count = count_reg;

    // An accepted command keeps the block busy for at least the slot scan.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && !done)
        else $error("command accepted but block not busy");

    // A result strobe lasts one cycle and is never followed directly by another.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // A successful result always reports the pin as attached, except detach.
    a_ok_attached: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_OK) && (cmd_reg != CMD_DETACH) |-> is_attached)
        else $error("successful command reports pin detached");

    // A failed command generates no pulses.
    a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != ST_OK) |->
            (pulse_count == '0) && (pulse_us == '0) && (low_time_us == '0))
        else $error("failed command reports pulses");

    // The saturated low time never exceeds the refresh period.
    a_low_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (low_time_us <= refresh_reg))
        else $error("low time exceeds refresh period");

endmodule

[rtl/core/sstps_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstps_alu
// Shared 16-bit adder and subtractor with carry and borrow out.
// ----------------------------------------------------------------------------
module sstps_alu
    import sstps_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [ALU_W:0] sum;

    always_comb
    begin
        case (req.op)
            ALU_ADD: sum = {1'b0, req.a} + {1'b0, req.b};
            ALU_SUB: sum = {1'b0, req.a} - {1'b0, req.b};
            default: sum = '0;
        endcase
    end

    assign rsp.res   = sum[ALU_W-1:0];
    assign rsp.carry = sum[ALU_W];

endmodule

[rtl/core/sstps_slot_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstps_slot_table
// Servo slots: used marks, pin numbers and stored pulse widths.
// ----------------------------------------------------------------------------
module sstps_slot_table
    import sstps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  slot_t            scan_idx,
    input  slot_t            rd_idx,
    input  tbl_wr_t          wr,
    output logic             scan_used,
    output logic [PIN_W-1:0] scan_pin,
    output logic [US_W-1:0]  rd_width
);

    logic [SLOTS-1:0]  used_reg;
    logic [PIN_W-1:0]  pin_reg   [SLOTS];
    logic [US_W-1:0]   width_reg [SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (wr.attach)
        begin
            used_reg[wr.idx] <= 1'b1;
        end
        else if (wr.detach)
        begin
            used_reg[wr.idx] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.attach)
        begin
            pin_reg[wr.idx] <= wr.pin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                width_reg[i] <= RST_DEFAULT_PULSE;
            end
        end
        else if (wr.attach || wr.set_width)
        begin
            width_reg[wr.idx] <= wr.width;
        end
    end

    assign scan_used = used_reg[scan_idx];
    assign scan_pin  = pin_reg[scan_idx];
    assign rd_width  = width_reg[rd_idx];

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the servo slot table pulse setter.
// ----------------------------------------------------------------------------
// A short table of directed commands covers the field extremes, each defined
// command code, two unused codes and the slot table's corner cases: full table,
// duplicate pins, detach of a duplicate and unknown pins. Random commands,
// mostly on a fixed pool of pins, follow under several register settings with
// the extremes and a minimum above the maximum. Each result is checked against
// its hand-written row or a predictor with its own copy of table and registers.
// ----------------------------------------------------------------------------
module tb_top;
    import sstps_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;
    localparam int NUM_REGS     = 5;
    localparam int PHASE_ITEMS  = 190;
    localparam int POOL_SIZE    = 8;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed
    {
        logic [STATUS_W-1:0]   status;
        logic [OUT_SLOT_W-1:0] slot;
        logic                  attached;
        logic [US_W-1:0]       pulse;
        logic [US_W-1:0]       low_time;
        logic [COUNT_W-1:0]    count;
    } servo_result_t;

    typedef struct packed
    {
        logic [CMD_W-1:0] op;
        logic [PIN_W-1:0] pin;
        logic [US_W-1:0]  angle;
        logic [US_W-1:0]  width;
        logic             typed;
        servo_result_t    want;
    } directed_row_t;

    // Rows with typed set carry a hand-written result for the reset settings.
    localparam directed_row_t DIRECTED_ROWS [26] = '{
        '{CMD_QUERY,    8'h05, 16'd0,    16'd0,     1'b1,
          '{ST_NOT_ATT, 3'd0, 1'b0, 16'd0, 16'd0, 8'd0}},
        '{CMD_DETACH,   8'h05, 16'd0,    16'd0,     1'b1,
          '{ST_NOT_ATT, 3'd0, 1'b0, 16'd0, 16'd0, 8'd0}},
        '{CMD_WR_ANGLE, 8'h05, 16'd90,   16'd0,     1'b1,
          '{ST_NOT_ATT, 3'd0, 1'b0, 16'd0, 16'd0, 8'd0}},
        '{CMD_ATTACH,   8'h05, 16'd0,    16'd0,     1'b1,
          '{ST_OK, 3'd0, 1'b1, 16'd1500, 16'd18500, 8'd10}},
        '{CMD_WR_ANGLE, 8'h05, 16'd0,    16'd0,     1'b1,
          '{ST_OK, 3'd0, 1'b1, 16'd1000, 16'd19000, 8'd10}},
        '{CMD_WR_ANGLE, 8'h05, 16'd180,  16'd0,     1'b1,
          '{ST_OK, 3'd0, 1'b1, 16'd2000, 16'd18000, 8'd10}},
        '{CMD_WR_ANGLE, 8'h05, 16'h8000, 16'd0,     1'b1,
          '{ST_OK, 3'd0, 1'b1, 16'd1000, 16'd19000, 8'd10}},
        '{CMD_WR_ANGLE, 8'h05, 16'h7FFF, 16'd0,     1'b1,
          '{ST_OK, 3'd0, 1'b1, 16'd2000, 16'd18000, 8'd10}},
        '{CMD_WR_ANGLE, 8'h05, 16'd90,   16'd0,     1'b1,
          '{ST_OK, 3'd0, 1'b1, 16'd1500, 16'd18500, 8'd10}},
        '{CMD_WR_US,    8'h05, 16'd0,    16'd0,     1'b1,
          '{ST_OK, 3'd0, 1'b1, 16'd1000, 16'd19000, 8'd10}},
        '{CMD_WR_US,    8'h05, 16'd0,    16'hFFFF,  1'b1,
          '{ST_OK, 3'd0, 1'b1, 16'd2000, 16'd18000, 8'd10}},
        '{CMD_WR_US,    8'h05, 16'd0,    16'd1234,  1'b1,
          '{ST_OK, 3'd0, 1'b1, 16'd1234, 16'd18766, 8'd10}},
        '{CMD_QUERY,    8'h05, 16'd0,    16'd0,     1'b1,
          '{ST_OK, 3'd0, 1'b1, 16'd1234, 16'd18766, 8'd0}},
        '{CMD_RSVD_5,   8'h05, 16'd0,    16'd0,     1'b1,
          '{ST_OK, 3'd0, 1'b1, 16'd1234, 16'd18766, 8'd0}},
        '{CMD_ATTACH,   8'h05, 16'd0,    16'd0,     1'b1,
          '{ST_OK, 3'd1, 1'b1, 16'd1500, 16'd18500, 8'd10}},
        '{CMD_ATTACH,   8'h00, 16'd0,    16'd0,     1'b0, '0},
        '{CMD_ATTACH,   8'hFF, 16'd0,    16'd0,     1'b0, '0},
        '{CMD_ATTACH,   8'hAA, 16'd0,    16'd0,     1'b0, '0},
        '{CMD_ATTACH,   8'h55, 16'd0,    16'd0,     1'b0, '0},
        '{CMD_ATTACH,   8'h0F, 16'd0,    16'd0,     1'b0, '0},
        '{CMD_ATTACH,   8'hF0, 16'd0,    16'd0,     1'b0, '0},
        '{CMD_ATTACH,   8'h33, 16'd0,    16'd0,     1'b1,
          '{ST_NO_FREE, 3'd0, 1'b0, 16'd0, 16'd0, 8'd0}},
        '{CMD_ATTACH,   8'hFF, 16'd0,    16'd0,     1'b1,
          '{ST_NO_FREE, 3'd0, 1'b1, 16'd0, 16'd0, 8'd0}},
        '{CMD_DETACH,   8'h05, 16'd0,    16'd0,     1'b1,
          '{ST_OK, 3'd0, 1'b1, 16'd0, 16'd0, 8'd0}},
        '{CMD_DETACH,   8'h05, 16'd0,    16'd0,     1'b1,
          '{ST_OK, 3'd1, 1'b0, 16'd0, 16'd0, 8'd0}},
        '{CMD_RSVD_7,   8'hFF, 16'd0,    16'd0,     1'b0, '0}
    };

    // Attaches use only these pins, so the table keeps draining and refilling.
    localparam logic [PIN_W-1:0] PIN_POOL [POOL_SIZE] =
        '{8'h05, 8'h00, 8'hFF, 8'hAA, 8'h55, 8'h0F, 8'hF0, 8'h33};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [CMD_W-1:0]      cmd = '0;
    logic [PIN_W-1:0]      pin_id = '0;
    logic [US_W-1:0]       angle_deg = '0;
    logic [US_W-1:0]       width_request_us = '0;
    logic                  done;
    logic [STATUS_W-1:0]   status;
    logic [OUT_SLOT_W-1:0] slot_index;
    logic                  is_attached;
    logic [US_W-1:0]       pulse_us;
    logic [US_W-1:0]       low_time_us;
    logic [COUNT_W-1:0]    pulse_count;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [US_W-1:0]       cfg_data = '0;

    servo_slot_table_pulse_setter dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .cmd              (cmd),
        .pin_id           (pin_id),
        .angle_deg        (angle_deg),
        .width_request_us (width_request_us),
        .done             (done),
        .status           (status),
        .slot_index       (slot_index),
        .is_attached      (is_attached),
        .pulse_us         (pulse_us),
        .low_time_us      (low_time_us),
        .pulse_count      (pulse_count),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #5 clk = ~clk;

    // Predictor copy of the registers and the slot table.
    logic [US_W-1:0]    min_us;
    logic [US_W-1:0]    max_us;
    logic [US_W-1:0]    default_us;
    logic [US_W-1:0]    period_us;
    logic [COUNT_W-1:0] pulses;
    logic               tbl_used  [SLOTS];
    logic [PIN_W-1:0]   tbl_pin   [SLOTS];
    logic [US_W-1:0]    tbl_width [SLOTS];

    servo_result_t pending_results [$];
    int            mismatch_count = 0;
    int            burst_left = 0;

    function automatic int find_pin_slot(logic [PIN_W-1:0] pin);
        for (int i = 0; i < SLOTS; i++)
            if (tbl_used[i] && tbl_pin[i] == pin)
                return i;
        return -1;
    endfunction

    function automatic int find_free_slot();
        for (int i = 0; i < SLOTS; i++)
            if (!tbl_used[i])
                return i;
        return -1;
    endfunction

    function automatic logic [US_W-1:0] low_time_of(logic [US_W-1:0] w);
        return (period_us > w) ? period_us - w : '0;
    endfunction

    function automatic logic [US_W-1:0] angle_width(logic [US_W-1:0] raw);
        int unsigned ang;
        if (raw[US_W-1])
            ang = 0;
        else if (raw > ANGLE_MAX)
            ang = ANGLE_MAX;
        else
            ang = raw;
        // The quotient truncates toward zero in both slope directions.
        if (max_us >= min_us)
            return US_W'(min_us + (ang * (max_us - min_us)) / ANGLE_MAX);
        return US_W'(min_us - (ang * (min_us - max_us)) / ANGLE_MAX);
    endfunction

    function automatic logic [US_W-1:0] clamp_us(logic [US_W-1:0] raw);
        logic [US_W-1:0] w;
        w = raw;
        if (w < min_us)
            w = min_us;
        if (w > max_us)
            w = max_us;
        return w;
    endfunction

    function automatic servo_result_t predict_servo_result(logic [CMD_W-1:0] op,
                                                           logic [PIN_W-1:0] pin,
                                                           logic [US_W-1:0] ang,
                                                           logic [US_W-1:0] wreq);
        servo_result_t r;
        int            s;
        r = '0;
        r.status = ST_OK;
        if (op == CMD_ATTACH)
        begin
            s = find_free_slot();
            if (s < 0)
            begin
                r.status   = ST_NO_FREE;
                r.attached = (find_pin_slot(pin) >= 0);
            end
            else
            begin
                tbl_used[s]  = 1'b1;
                tbl_pin[s]   = pin;
                tbl_width[s] = default_us;
                r.slot       = OUT_SLOT_W'(s);
                r.attached   = 1'b1;
                r.pulse      = default_us;
                r.low_time   = low_time_of(default_us);
                r.count      = pulses;
            end
        end
        else
        begin
            s = find_pin_slot(pin);
            if (s < 0)
                r.status = ST_NOT_ATT;
            else if (op == CMD_DETACH)
            begin
                tbl_used[s] = 1'b0;
                r.slot      = OUT_SLOT_W'(s);
                r.attached  = (find_pin_slot(pin) >= 0);
            end
            else if (op == CMD_WR_ANGLE || op == CMD_WR_US)
            begin
                r.pulse      = (op == CMD_WR_ANGLE) ? angle_width(ang) : clamp_us(wreq);
                tbl_width[s] = r.pulse;
                r.slot       = OUT_SLOT_W'(s);
                r.attached   = 1'b1;
                r.low_time   = low_time_of(r.pulse);
                r.count      = pulses;
            end
            else
            begin
                // Query, and the unused codes behave the same way.
                r.slot     = OUT_SLOT_W'(s);
                r.attached = 1'b1;
                r.pulse    = tbl_width[s];
                r.low_time = low_time_of(r.pulse);
            end
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    task automatic send_command(logic [CMD_W-1:0] op, logic [PIN_W-1:0] pin,
                                logic [US_W-1:0] ang, logic [US_W-1:0] wreq,
                                logic typed, servo_result_t want);
        servo_result_t r;
        int            gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start            <= 1'b1;
        cmd              <= op;
        pin_id           <= pin;
        angle_deg        <= ang;
        width_request_us <= wreq;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // The predictor runs on every row so the table stays in step.
        r = predict_servo_result(op, pin, ang, wreq);
        pending_results.push_back(typed ? want : r);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_settings(logic [US_W-1:0] lo, logic [US_W-1:0] hi,
                                  logic [US_W-1:0] dflt, logic [US_W-1:0] period,
                                  logic [US_W-1:0] count_data);
        logic [US_W-1:0] vals [NUM_REGS];
        int              gap;
        vals = '{lo, hi, dflt, period, count_data};
        for (int i = 0; i < NUM_REGS; i++)
        begin
            gap = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                cfg_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (CFG_IDX_W'(i))
                REG_MIN_PULSE:     min_us     = vals[i];
                REG_MAX_PULSE:     max_us     = vals[i];
                REG_DEFAULT_PULSE: default_us = vals[i];
                REG_REFRESH:       period_us  = vals[i];
                REG_PULSES:        pulses     = vals[i][COUNT_W-1:0];
                default:           ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_commands(int n);
        logic [CMD_W-1:0] op;
        logic [PIN_W-1:0] pin;
        logic [US_W-1:0]  ang;
        logic [US_W-1:0]  wreq;
        int               r;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 20)
                op = CMD_ATTACH;
            else if (r < 38)
                op = CMD_DETACH;
            else if (r < 58)
                op = CMD_WR_ANGLE;
            else if (r < 78)
                op = CMD_WR_US;
            else if (r < 94)
                op = CMD_QUERY;
            else
                op = CMD_W'($urandom_range(CMD_RSVD_5, CMD_RSVD_7));

            // Stray pins are never attached, so the table cannot clog up.
            if (op == CMD_ATTACH || $urandom_range(0, 99) < 85)
                pin = PIN_POOL[$urandom_range(0, POOL_SIZE - 1)];
            else
                pin = PIN_W'($urandom_range(0, 255));

            r = $urandom_range(0, 99);
            if (r < 40)
                ang = US_W'($urandom_range(0, ANGLE_MAX));
            else if (r < 55)
                ang = US_W'($urandom_range(170, 200));
            else if (r < 65)
                ang = US_W'(int'($urandom_range(0, 20)) - 10);
            else
                ang = US_W'($urandom_range(0, 65535));

            r = $urandom_range(0, 99);
            if (r < 20)
                wreq = min_us + US_W'(int'($urandom_range(0, 10)) - 5);
            else if (r < 40)
                wreq = max_us + US_W'(int'($urandom_range(0, 10)) - 5);
            else
                wreq = US_W'($urandom_range(0, 65535));

            send_command(op, pin, ang, wreq, 1'b0, '0);
        end
    endtask

    task automatic report_mismatch(servo_result_t want, servo_result_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH at %0t: expected status=%0d slot=%0d att=%0b pulse=%0d low=%0d count=%0d, got status=%0d slot=%0d att=%0b pulse=%0d low=%0d count=%0d",
                     $realtime, want.status, want.slot, want.attached, want.pulse,
                     want.low_time, want.count, got.status, got.slot, got.attached,
                     got.pulse, got.low_time, got.count);
    endtask

    // Results are sampled at the edge that ends their single valid cycle.
    always @(posedge clk)
    begin
        servo_result_t got;
        servo_result_t want;
        if (rst_n && done)
        begin
            got = '{status, slot_index, is_attached, pulse_us, low_time_us, pulse_count};
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("MISMATCH at %0t: result with no command outstanding",
                             $realtime);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                    report_mismatch(want, got);
            end
        end
    end

    initial
    begin
        min_us     = RST_MIN_PULSE;
        max_us     = RST_MAX_PULSE;
        default_us = RST_DEFAULT_PULSE;
        period_us  = RST_REFRESH;
        pulses     = RST_PULSES;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_used[i]  = 1'b0;
            tbl_pin[i]   = '0;
            tbl_width[i] = RST_DEFAULT_PULSE;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < $size(DIRECTED_ROWS); k++)
            send_command(DIRECTED_ROWS[k].op, DIRECTED_ROWS[k].pin,
                         DIRECTED_ROWS[k].angle, DIRECTED_ROWS[k].width,
                         DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].want);
        drain();

        write_settings(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'h0000);
        random_commands(PHASE_ITEMS);
        drain();

        // Minimum above maximum: the angle slope runs downward.
        write_settings(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_commands(PHASE_ITEMS);
        drain();

        write_settings(16'd500, 16'd2500, 16'd1500, 16'd20000,
                       US_W'($urandom_range(0, 65535)));
        random_commands(PHASE_ITEMS);
        drain();

        write_settings(16'd1500, 16'd1500, 16'd1500, 16'd1500, 16'h0001);
        random_commands(PHASE_ITEMS);
        drain();

        write_settings(US_W'($urandom_range(0, 65535)), US_W'($urandom_range(0, 65535)),
                       US_W'($urandom_range(0, 65535)), US_W'($urandom_range(0, 65535)),
                       US_W'($urandom_range(0, 65535)));
        random_commands(PHASE_ITEMS);
        drain();

        write_settings(RST_MIN_PULSE, RST_MAX_PULSE, RST_DEFAULT_PULSE, RST_REFRESH,
                       US_W'(RST_PULSES));
        random_commands(PHASE_ITEMS);
        drain();

        repeat (60) @(posedge clk);
        if (mismatch_count == 0)
            $display("servo_slot_table_pulse_setter verification clean");
        else
            $display("servo_slot_table_pulse_setter verification failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("servo_slot_table_pulse_setter verification failed");
        $finish;
    end

endmodule
